[rtl/rmp_pkg.sv]
// ----------------------------------------------------------------------------
// rmp_pkg: shared types and constants of the radar measurement prediction core
// Holds the stage record types, the arctangent table and fixed-point limits.
// ----------------------------------------------------------------------------
package rmp_pkg;

  localparam int DataW     = 32;
  localparam int FracBits  = 16;
  localparam int BearW     = FracBits + 3;
  localparam int AngFrac   = 30;
  localparam int CordSteps = 31;
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 64;
  localparam int CxW       = 45;
  localparam int CzW       = 35;
  localparam int NormBit   = 40;

  localparam logic signed [CzW-1:0] PiQ30 = 35'sd3373259426;
  localparam int RndShift = AngFrac - FracBits;
  localparam logic signed [CzW-1:0] RndHalf = 35'sd1 <<< (RndShift - 1);
  localparam logic signed [CzW-1:0] BearLim = (PiQ30 + RndHalf) >>> RndShift;

  // Stage index of each part of the pipeline.
  localparam int StSqrt0 = 4;
  localparam int StDiv0  = StSqrt0 + SqrtSteps;
  localparam int StOut   = StDiv0 + DivSteps;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [CxW-1:0] x;
    logic signed [CxW-1:0] y;
    logic signed [CzW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [DataW-1:0] dvs;
    logic [DataW-1:0] rem;
    logic [63:0]      dvd;
    logic [63:0]      quo;
  } div_t;

  typedef struct packed {
    logic [63:0] dmag;
    logic        dneg;
  } dot_t;

  typedef struct packed {
    logic [BearW-1:0] bear;
    logic [DataW-1:0] rng;
    logic             dneg;
  } side_t;

  // Truncated atan(2^-i) in Q2.30.
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h3243F6A8;
      5'd1:  a = 32'h1DAC6705;
      5'd2:  a = 32'h0FADBAFC;
      5'd3:  a = 32'h07F56EA6;
      5'd4:  a = 32'h03FEAB76;
      5'd5:  a = 32'h01FFD55B;
      5'd6:  a = 32'h00FFFAAA;
      5'd7:  a = 32'h007FFF55;
      5'd8:  a = 32'h003FFFEA;
      5'd9:  a = 32'h001FFFFD;
      5'd10: a = 32'h000FFFFF;
      5'd11: a = 32'h0007FFFF;
      5'd12: a = 32'h0003FFFF;
      5'd13: a = 32'h0001FFFF;
      5'd14: a = 32'h0000FFFF;
      5'd15: a = 32'h00007FFF;
      5'd16: a = 32'h00003FFF;
      5'd17: a = 32'h00001FFF;
      5'd18: a = 32'h00000FFF;
      5'd19: a = 32'h000007FF;
      5'd20: a = 32'h000003FF;
      5'd21: a = 32'h000001FF;
      5'd22: a = 32'h000000FF;
      5'd23: a = 32'h0000007F;
      5'd24: a = 32'h0000003F;
      5'd25: a = 32'h0000001F;
      5'd26: a = 32'h0000000F;
      5'd27: a = 32'h00000008;
      5'd28: a = 32'h00000004;
      5'd29: a = 32'h00000002;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

[rtl/rmp_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// rmp_sqrt_cell: one digit of the integer square root
// Tries one root bit against the remainder and registers the new pair.
// ----------------------------------------------------------------------------
module rmp_sqrt_cell import rmp_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [4:0] digit_i,
  input  sqrt_t      data_i,
  output sqrt_t      data_o
);

  sqrt_t       data_d;
  sqrt_t       data_q;
  logic [63:0] bit_w;
  logic [63:0] trial;

  // Root bit weight is 4^digit.
  always_comb begin
    bit_w = 64'd1 << {digit_i, 1'b0};
    trial = data_i.res + bit_w;
    if (data_i.n >= trial) begin
      data_d.n   = data_i.n - trial;
      data_d.res = (data_i.res >> 1) + bit_w;
    end else begin
      data_d.n   = data_i.n;
      data_d.res = data_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

[rtl/rmp_cordic_cell.sv]
// ----------------------------------------------------------------------------
// rmp_cordic_cell: one vectoring step of the bearing CORDIC
// Rotates the vector toward the x axis and accumulates the angle.
// ----------------------------------------------------------------------------
module rmp_cordic_cell import rmp_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [4:0] step_i,
  input  cordic_t    data_i,
  output cordic_t    data_o
);

  cordic_t               data_d;
  cordic_t               data_q;
  logic signed [CxW-1:0] xs;
  logic signed [CxW-1:0] ys;
  logic signed [CzW-1:0] ang;

  // Clockwise rotation while y is above zero.
  always_comb begin
    xs  = data_i.x >>> step_i;
    ys  = data_i.y >>> step_i;
    ang = $signed({{(CzW-32){1'b0}}, atan_lut(step_i)});
    if (data_i.y > 0) begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + ang;
    end else begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

[rtl/rmp_div_cell.sv]
// ----------------------------------------------------------------------------
// rmp_div_cell: one quotient bit of the restoring divider
// Shifts in the next dividend bit and subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module rmp_div_cell import rmp_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t data_i,
  output div_t data_o
);

  div_t           data_d;
  div_t           data_q;
  logic [DataW:0] part;

  // The remainder stays below the divisor, so one extra bit is enough.
  always_comb begin
    part       = {data_i.rem, data_i.dvd[63]};
    data_d.dvs = data_i.dvs;
    data_d.dvd = {data_i.dvd[62:0], 1'b0};
    if (part >= {1'b0, data_i.dvs}) begin
      data_d.rem = DataW'(part - {1'b0, data_i.dvs});
      data_d.quo = {data_i.quo[62:0], 1'b1};
    end else begin
      data_d.rem = part[DataW-1:0];
      data_d.quo = {data_i.quo[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

[rtl/radar_measurement_prediction_core.sv]
// ----------------------------------------------------------------------------
// radar_measurement_prediction_core: Cartesian state to radar observation
// Gives range, bearing and range rate of a tracked object, one per request.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries pos_x, pos_y, vel_x, vel_y (signed Q16.16).
//   A request is taken when in_valid_i is high and in_stall_o is low.
//   The output channel gives range, bearing, range_rate and valid_res; a
//   result is taken when out_valid_o is high and out_stall_i is low.
//   The configuration channel writes min_range whenever cfg_valid_i is high;
//   cfg_ready_o is always high. Write it only while the core is idle.
//   Throughput is one request per cycle while no result is stalled. From the
//   accepting edge until the result is on the outputs, a request passes the
//   input register, three front stages, the chain of 32 square root cells,
//   the chain of 64 divider cells and the output register. The 31 CORDIC
//   cells and the angle rounding register run beside the square root chain.
//   When the receiver stalls a waiting result, the whole chain holds and
//   in_stall_o rises, so no result is lost.
//   Reset clears the chain's valid flags and sets min_range to 655. A
//   result whose range is not above min_range has all fields zero.
// ----------------------------------------------------------------------------
module radar_measurement_prediction_core import rmp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] pos_x_i,
  input  logic signed [DataW-1:0] pos_y_i,
  input  logic signed [DataW-1:0] vel_x_i,
  input  logic signed [DataW-1:0] vel_y_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [DataW-1:0]        range_o,
  output logic signed [BearW-1:0] bearing_o,
  output logic signed [DataW-1:0] range_rate_o,
  output logic                    valid_res_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [15:0]             cfg_data_i
);

  logic en;
  logic vld_q [StOut+1];

  // Configuration register.
  logic [15:0] min_range_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q <= 16'd655;
    end else if (cfg_valid_i) begin
      min_range_q <= cfg_data_i;
    end
  end

  // The chain moves unless a finished result is held back.
  assign en         = !(vld_q[StOut] && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[StOut];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= StOut; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i <= StOut; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Stage 0: input register.
  logic signed [DataW-1:0] px_q, py_q, vx_q, vy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      vx_q <= vel_x_i;
      vy_q <= vel_y_i;
    end
  end

  // Stage 1: magnitudes, signs and the half plane fold for the bearing.
  logic [DataW-1:0]        apx_q, apy_q, avx_q, avy_q;
  logic                    npx_q, npy_q, nvx_q, nvy_q;
  logic signed [DataW:0]   xf_d, yf_d, xf_q, yf_q;
  logic signed [CzW-1:0]   z0_d, z0_q;

  always_comb begin
    xf_d = {px_q[DataW-1], px_q};
    yf_d = {py_q[DataW-1], py_q};
    z0_d = '0;
    if (px_q[DataW-1]) begin
      xf_d = -xf_d;
      yf_d = -yf_d;
      z0_d = py_q[DataW-1] ? -PiQ30 : PiQ30;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      apx_q <= px_q[DataW-1] ? DataW'(-px_q) : DataW'(px_q);
      apy_q <= py_q[DataW-1] ? DataW'(-py_q) : DataW'(py_q);
      avx_q <= vx_q[DataW-1] ? DataW'(-vx_q) : DataW'(vx_q);
      avy_q <= vy_q[DataW-1] ? DataW'(-vy_q) : DataW'(vy_q);
      npx_q <= px_q[DataW-1];
      npy_q <= py_q[DataW-1];
      nvx_q <= vx_q[DataW-1];
      nvy_q <= vy_q[DataW-1];
      xf_q  <= xf_d;
      yf_q  <= yf_d;
      z0_q  <= z0_d;
    end
  end

  // Stage 2: products and the normalizing shift of the bearing vector.
  logic [63:0]            sq1_q, sq2_q, p1_q, p2_q;
  logic                   s1_q, s2_q;
  logic signed [DataW:0]  xf2_q, yf2_q;
  logic signed [CzW-1:0]  z02_q;
  logic [5:0]             sh_d, sh_q;
  logic [DataW-1:0]       mx;
  logic [DataW-1:0]       ay;

  always_comb begin
    ay = yf_q[DataW] ? DataW'(-yf_q) : DataW'(yf_q);
    mx = (DataW'(xf_q) > ay) ? DataW'(xf_q) : ay;
    sh_d = '0;
    for (int b = 0; b < DataW; b++) begin
      if (mx[b]) sh_d = 6'(NormBit - b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq1_q <= apx_q * apx_q;
      sq2_q <= apy_q * apy_q;
      p1_q  <= apx_q * avx_q;
      p2_q  <= apy_q * avy_q;
      s1_q  <= npx_q ^ nvx_q;
      s2_q  <= npy_q ^ nvy_q;
      xf2_q <= xf_q;
      yf2_q <= yf_q;
      z02_q <= z0_q;
      sh_q  <= sh_d;
    end
  end

  // Stage 3: squared sum, signed dot product and the normalized vector.
  sqrt_t   sq_in_q;
  cordic_t cd_in_q;
  dot_t    dot_d, dot_q;
  logic    n1, n2;

  always_comb begin
    n1 = (p1_q != 64'd0) && s1_q;
    n2 = (p2_q != 64'd0) && s2_q;
    if (n1 == n2) begin
      dot_d.dmag = p1_q + p2_q;
      dot_d.dneg = n1;
    end else if (p1_q >= p2_q) begin
      dot_d.dmag = p1_q - p2_q;
      dot_d.dneg = n1;
    end else begin
      dot_d.dmag = p2_q - p1_q;
      dot_d.dneg = n2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_in_q.n   <= sq1_q + sq2_q;
      sq_in_q.res <= '0;
      cd_in_q.x   <= CxW'(xf2_q) <<< sh_q;
      cd_in_q.y   <= CxW'(yf2_q) <<< sh_q;
      cd_in_q.z   <= z02_q;
      dot_q       <= dot_d;
    end
  end

  // Square root chain and CORDIC chain side by side.
  sqrt_t   sq_c [SqrtSteps+1];
  cordic_t cd_c [CordSteps+1];
  assign sq_c[0] = sq_in_q;
  assign cd_c[0] = cd_in_q;

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    rmp_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .digit_i (5'(SqrtSteps - 1 - j)),
      .data_i  (sq_c[j]),
      .data_o  (sq_c[j+1])
    );
  end

  for (genvar j = 0; j < CordSteps; j++) begin : g_cordic
    rmp_cordic_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .step_i (5'(j)),
      .data_i (cd_c[j]),
      .data_o (cd_c[j+1])
    );
  end

  // Round the angle to the output format and clamp it to plus or minus pi.
  logic signed [CzW-1:0]   zr;
  logic signed [BearW-1:0] bear_q;
  always_comb begin
    zr = (cd_c[CordSteps].z + RndHalf) >>> RndShift;
    if (zr > BearLim) zr = BearLim;
    if (zr < -BearLim) zr = -BearLim;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bear_q <= zr[BearW-1:0];
    end
  end

  // Dot product waits for the square root.
  dot_t dly_dot_q [SqrtSteps];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_dot_q[0] <= dot_q;
      for (int i = 1; i < SqrtSteps; i++) dly_dot_q[i] <= dly_dot_q[i-1];
    end
  end

  // Divider chain with range, bearing and sign alongside.
  div_t  dv_c [DivSteps+1];
  side_t side_q [DivSteps];

  // The divider starts with the root as divisor and the dot product magnitude.
  assign dv_c[0] = {sq_c[SqrtSteps].res[DataW-1:0], {DataW{1'b0}},
                    dly_dot_q[SqrtSteps-1].dmag, 64'd0};

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    rmp_div_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .data_i (dv_c[j]),
      .data_o (dv_c[j+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].bear <= bear_q;
      side_q[0].rng  <= sq_c[SqrtSteps].res[DataW-1:0];
      side_q[0].dneg <= dly_dot_q[SqrtSteps-1].dneg;
      for (int i = 1; i < DivSteps; i++) side_q[i] <= side_q[i-1];
    end
  end

  // Saturate the quotient, gate by the minimum range and register the result.
  localparam logic [63:0] MaxPos = (64'd1 << (DataW - 1)) - 64'd1;
  side_t       sd;
  logic [63:0] q;
  logic [63:0] qs;
  logic        ok;

  always_comb begin
    sd = side_q[DivSteps-1];
    q  = dv_c[DivSteps].quo;
    ok = sd.rng > {{(DataW-16){1'b0}}, min_range_q};
    if (sd.dneg) begin
      qs = (q > MaxPos + 64'd1) ? MaxPos + 64'd1 : q;
      qs = 64'd0 - qs;
    end else begin
      qs = (q > MaxPos) ? MaxPos : q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      range_o      <= ok ? sd.rng : '0;
      bearing_o    <= ok ? sd.bear : '0;
      range_rate_o <= ok ? qs[DataW-1:0] : '0;
      valid_res_o  <= ok;
    end
  end

endmodule
